[sv/gbd_pkg.sv]
`timescale 1ns / 1ps
// gbd_pkg: shared constants for the breadth-first distance block.
// No dependencies; imported by the interfaces, the top level and the testbench.
package gbd_pkg;

  // Command codes carried by an input item
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  // Fixed field widths of the channels
  localparam int CMD_W  = 1;
  localparam int NODE_W = 4;
  localparam int DIST_W = 4;
  localparam int CNT_W  = 5;

  // Largest node count the 4-bit node fields can address
  localparam int NODE_CAP = 16;

  // Reset value of the node count register
  localparam logic [CNT_W-1:0] NUM_NODES_RST = 5'd16;

endpackage

[sv/gbd_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the breadth-first distance block: edge/run items,
// per-node results and the node count write port. Depends on gbd_pkg.

interface gbd_in_if import gbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;

  modport source (output valid, command, first_node, second_node, input ready);
  modport sink   (input valid, command, first_node, second_node, output ready);
endinterface

interface gbd_out_if import gbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_index;
  logic              reached;
  logic [DIST_W-1:0] hop_distance;
  logic              has_parent;
  logic [NODE_W-1:0] parent_node;
  logic              last_result;

  modport source (output valid, node_index, reached, hop_distance, has_parent,
                  parent_node, last_result, input ready);
  modport sink   (input valid, node_index, reached, hop_distance, has_parent,
                  parent_node, last_result, output ready);
endinterface

interface gbd_cfg_if import gbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] num_nodes;

  modport source (output valid, num_nodes, input ready);
  modport sink   (input valid, num_nodes, output ready);
endinterface

[sv/gbd_ram.sv]
`timescale 1ns / 1ps
// gbd_ram: simple dual-port RAM, one write port and one registered read port.
// No dependencies; used for the adjacency rows, node info and node queue.
module gbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/graph_breadth_first_distances.sv]
`timescale 1ns / 1ps
// graph_breadth_first_distances: BFS hop distances over a bit adjacency matrix.
// Depends on gbd_pkg, the channel interfaces in gbd_if and gbd_ram.
//
//  channel  | dir | payload                                          | item
//  ---------+-----+--------------------------------------------------+---------------------
//  in_ch    | in  | command, first_node, second_node                 | add edge / run search
//  out_ch   | out | node_index, reached, hop_distance, has_parent,   | one per node in use
//           |     | parent_node, last_result                         |
//  cfg_ch   | in  | num_nodes                                        | node count write
//
// An add item is a read-modify-write of two rows in the adjacency RAM (ADD_A, ADD_B).
// A run seeds the queue with the source if it is in use, then for each dequeued node
// passes POP, POP_W and ROW_W, which wait on the registered reads of queue, adjacency
// and info RAMs, and SCAN, which pushes one newly found neighbor per pass. POP then
// finds the queue empty, and EMIT_RD and EMIT_LD send one result per node in use.
// Reset (synchronous, rst_n low) empties the matrix at once through row valid bits.
// Input is taken only between commands; a pending result may stall out_ch freely.
module graph_breadth_first_distances import gbd_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input logic    clk,
  input logic    rst_n,
  gbd_in_if.sink   in_ch,
  gbd_out_if.source out_ch,
  gbd_cfg_if.sink  cfg_ch
);

  localparam int AW    = $clog2(MAX_NODES);
  localparam int CW    = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int NCAP  = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
  localparam int INF_W = DIST_W + AW + 1;

  // Sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ADD_A   = 4'd1;
  localparam logic [3:0] ST_ADD_B   = 4'd2;
  localparam logic [3:0] ST_POP     = 4'd3;
  localparam logic [3:0] ST_POP_W   = 4'd4;
  localparam logic [3:0] ST_ROW_W   = 4'd5;
  localparam logic [3:0] ST_SCAN    = 4'd6;
  localparam logic [3:0] ST_EMIT_RD = 4'd7;
  localparam logic [3:0] ST_EMIT_LD = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     num_nodes_r;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [MAX_NODES-1:0] adj_vld_r, adj_vld_nxt;
  logic                 adj_rd_vld_r, adj_rd_vld_nxt;
  logic [CW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        tail_r, tail_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        a_r, a_nxt;
  logic [AW-1:0]        b_r, b_nxt;
  logic [AW-1:0]        u_r, u_nxt;
  logic [DIST_W-1:0]    du_r, du_nxt;
  logic [MAX_NODES-1:0] row_r, row_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;

  // Output payload registers
  logic [NODE_W-1:0] o_node_r;
  logic              o_reached_r;
  logic [DIST_W-1:0] o_dist_r;
  logic              o_has_r;
  logic [NODE_W-1:0] o_parent_r;
  logic              o_last_r;

  // RAM ports
  logic                 adj_we, adj_re;
  logic [AW-1:0]        adj_waddr, adj_raddr;
  logic [MAX_NODES-1:0] adj_wdata, adj_rdata, adj_rd_eff;
  logic                 q_we, q_re;
  logic [AW-1:0]        q_waddr, q_raddr, q_wdata, q_rdata;
  logic                 inf_we, inf_re;
  logic [AW-1:0]        inf_waddr, inf_raddr;
  logic [INF_W-1:0]     inf_wdata, inf_rdata;

  logic                 in_acc;
  logic [AW-1:0]        in_a, in_b;
  logic                 edge_ok;
  logic [CNT_W-1:0]     n_raw, n_eff;
  logic [CW-1:0]        n_ext;
  logic [MAX_NODES-1:0] use_mask;
  logic [MAX_NODES-1:0] cand;
  logic [AW-1:0]        pick;
  logic                 emit_reached;
  logic                 emit_has;
  logic                 emit_last;

  gbd_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata)
  );

  gbd_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  gbd_ram #(.WIDTH(INF_W), .DEPTH(MAX_NODES)) u_info_ram (
    .clk(clk), .we(inf_we), .waddr(inf_waddr), .wdata(inf_wdata),
    .re(inf_re), .raddr(inf_raddr), .rdata(inf_rdata)
  );

  // Effective node count: zero counts as one, capped by the matrix and field size
  assign n_raw = (num_nodes_r == '0) ? CNT_W'(1) : num_nodes_r;
  assign n_eff = (n_raw > CNT_W'(NCAP)) ? CNT_W'(NCAP) : n_raw;
  assign n_ext = CW'(n_eff);

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      use_mask[j] = (CW'(j) < n_ext);
    end
  end

  // Rows never written since reset read as empty
  assign adj_rd_eff = adj_rdata & {MAX_NODES{adj_rd_vld_r}};

  // Lowest unvisited neighbor of the current row
  assign cand = row_r & ~visited_r;
  always_comb begin
    pick = '0;
    for (int j = MAX_NODES - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick = AW'(j);
      end
    end
  end

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign in_a    = AW'(in_ch.first_node);
  assign in_b    = AW'(in_ch.second_node);
  assign edge_ok = (CW'(in_ch.first_node) < CW'(MAX_NODES)) &&
                   (CW'(in_ch.second_node) < CW'(MAX_NODES));

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Result fields for the node being emitted
  assign emit_reached = visited_r[idx_r[AW-1:0]];
  assign emit_has     = emit_reached && inf_rdata[INF_W-1];
  assign emit_last    = ((idx_r + 1'b1) == n_ext);

  // Sequencer and memory control
  always_comb begin
    state_nxt      = state_r;
    visited_nxt    = visited_r;
    adj_vld_nxt    = adj_vld_r;
    adj_rd_vld_nxt = adj_rd_vld_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    idx_nxt        = idx_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    u_nxt          = u_r;
    du_nxt         = du_r;
    row_nxt        = row_r;
    out_load       = 1'b0;
    adj_we         = 1'b0;
    adj_waddr      = a_r;
    adj_wdata      = adj_rd_eff | (MAX_NODES'(1) << b_r);
    adj_re         = 1'b0;
    adj_raddr      = a_r;
    q_we           = 1'b0;
    q_waddr        = tail_r[AW-1:0];
    q_wdata        = pick;
    q_re           = 1'b0;
    q_raddr        = head_r[AW-1:0];
    inf_we         = 1'b0;
    inf_waddr      = pick;
    inf_wdata      = {1'b1, u_r, DIST_W'(du_r + 1'b1)};
    inf_re         = 1'b0;
    inf_raddr      = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_ADD) begin
            a_nxt = in_a;
            b_nxt = in_b;
            if (edge_ok) begin
              adj_re         = 1'b1;
              adj_raddr      = in_a;
              adj_rd_vld_nxt = adj_vld_r[in_a];
              state_nxt      = ST_ADD_A;
            end
          end else begin
            visited_nxt = '0;
            head_nxt    = '0;
            tail_nxt    = '0;
            idx_nxt     = '0;
            state_nxt   = ST_EMIT_RD;
            // Seed the queue with the source when it is in use
            if (CW'(in_ch.first_node) < n_ext) begin
              visited_nxt       = '0;
              visited_nxt[in_a] = 1'b1;
              inf_we            = 1'b1;
              inf_waddr         = in_a;
              inf_wdata         = '0;
              q_we              = 1'b1;
              q_waddr           = '0;
              q_wdata           = in_a;
              tail_nxt          = CW'(1);
              state_nxt         = ST_POP;
            end
          end
        end
      end
      ST_ADD_A: begin
        adj_we         = 1'b1;
        adj_waddr      = a_r;
        adj_wdata      = adj_rd_eff | (MAX_NODES'(1) << b_r);
        adj_vld_nxt[a_r] = 1'b1;
        adj_re         = 1'b1;
        adj_raddr      = b_r;
        adj_rd_vld_nxt = adj_vld_r[b_r];
        state_nxt      = ST_ADD_B;
      end
      ST_ADD_B: begin
        adj_we           = 1'b1;
        adj_waddr        = b_r;
        adj_wdata        = adj_rd_eff | (MAX_NODES'(1) << a_r);
        adj_vld_nxt[b_r] = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_POP: begin
        if (head_r == tail_r) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          q_re      = 1'b1;
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_POP_W;
        end
      end
      ST_POP_W: begin
        u_nxt          = q_rdata;
        adj_re         = 1'b1;
        adj_raddr      = q_rdata;
        adj_rd_vld_nxt = adj_vld_r[q_rdata];
        inf_re         = 1'b1;
        inf_raddr      = q_rdata;
        state_nxt      = ST_ROW_W;
      end
      ST_ROW_W: begin
        row_nxt   = adj_rd_eff & use_mask;
        du_nxt    = inf_rdata[DIST_W-1:0];
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cand == '0) begin
          state_nxt = ST_POP;
        end else begin
          visited_nxt[pick] = 1'b1;
          inf_we            = 1'b1;
          q_we              = 1'b1;
          tail_nxt          = tail_r + 1'b1;
        end
      end
      ST_EMIT_RD: begin
        inf_re    = 1'b1;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_nodes_r  <= NUM_NODES_RST;
      visited_r    <= '0;
      adj_vld_r    <= '0;
      adj_rd_vld_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      visited_r    <= visited_nxt;
      adj_vld_r    <= adj_vld_nxt;
      adj_rd_vld_r <= adj_rd_vld_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        num_nodes_r <= cfg_ch.num_nodes;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    u_r   <= u_nxt;
    du_r  <= du_nxt;
    row_r <= row_nxt;
    if (out_load) begin
      o_node_r    <= NODE_W'(idx_r);
      o_reached_r <= emit_reached;
      o_dist_r    <= emit_reached ? inf_rdata[DIST_W-1:0] : '0;
      o_has_r     <= emit_has;
      o_parent_r  <= emit_has ? NODE_W'(inf_rdata[DIST_W+AW-1:DIST_W]) : '0;
      o_last_r    <= emit_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.node_index   = o_node_r;
  assign out_ch.reached      = o_reached_r;
  assign out_ch.hop_distance = o_dist_r;
  assign out_ch.has_parent   = o_has_r;
  assign out_ch.parent_node  = o_parent_r;
  assign out_ch.last_result  = o_last_r;

  // Queue head never passes the tail
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  // Every visited node was pushed exactly once
  a_visit_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP || state_r == ST_POP_W || state_r == ST_ROW_W ||
     state_r == ST_SCAN) |-> ($countones(visited_r) == tail_r))
    else $error("visited count differs from queue pushes");

  // Results go out only after the queue has drained
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_RD || state_r == ST_EMIT_LD) |-> (head_r == tail_r))
    else $error("emitting with nodes still queued");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for graph_breadth_first_distances.
// Needs gbd_pkg, the channel interfaces in gbd_if and the block with its RAMs.
module testbench;
  import gbd_pkg::*;

  localparam int LIMIT_CYCLES    = 1_000_000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int END_CYCLES      = 200;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 33;
  localparam int SCRIPT_LEN      = 26;

  // One per-node search report as the block should emit it
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              reached;
    logic [DIST_W-1:0] hops;
    logic              has_parent;
    logic [NODE_W-1:0] parent;
    logic              last;
  } node_report_t;

  // Directed script: either an input item or a node count write
  typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_t;
  typedef struct packed {
    row_kind_t         kind;
    logic              cmd;
    logic [NODE_W-1:0] first;
    logic [NODE_W-1:0] second;
    logic              known;      // reach mask typed in, nothing else reached
    logic [15:0]       mask;
    logic [CNT_W-1:0]  count;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gbd_in_if  in_ch ();
  gbd_out_if out_ch ();
  gbd_cfg_if cfg_ch ();

  graph_breadth_first_distances dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the block's graph and node count
  logic [15:0]      link_rows [16];
  logic [CNT_W-1:0] node_count_reg;
  node_report_t     pending_reports [$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int searches_sent   = 0;
  int deepest_hop     = 0;
  int cycle_count     = 0;
  logic calm          = 1'b0;
  logic sink_steady   = 1'b0;
  logic hold_results  = 1'b0;
  logic hold_finished = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  // Breadth-first search over the mirrored matrix; queues one report per node in use.
  // A known row skips the search and takes its reach mask as the whole answer.
  function automatic void forecast_reports(input logic [NODE_W-1:0] src, input logic known,
                                           input logic [15:0] known_mask);
    int n, head, count, u;
    logic [15:0] seen;
    logic [DIST_W-1:0] hops [16];
    logic [4:0] via [16];
    logic [NODE_W-1:0] frontier [16];
    node_report_t r;
    if (node_count_reg == 0) n = 1;
    else if (int'(node_count_reg) > NODE_CAP) n = NODE_CAP;
    else n = int'(node_count_reg);
    seen = '0;
    head = 0;
    count = 0;
    for (int i = 0; i < 16; i++) begin
      hops[i] = '0;
      via[i] = '0;
      frontier[i] = '0;
    end
    if (known) begin
      seen = known_mask;
    end else if (int'(src) < n) begin
      seen[src] = 1'b1;
      frontier[0] = src;
      count = 1;
      while (count != 0) begin
        u = int'(frontier[head]);
        head = (head + 1) % 16;
        count--;
        // neighbors at or above the node count are not followed
        for (int i = 0; i < n; i++) begin
          if (link_rows[u][i] && !seen[i]) begin
            seen[i] = 1'b1;
            hops[i] = hops[u] + 4'd1;
            via[i] = {1'b1, 4'(u)};
            frontier[(head + count) % 16] = 4'(i);
            count++;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node = 4'(i);
      r.reached = seen[i];
      r.hops = seen[i] ? hops[i] : '0;
      r.has_parent = seen[i] & via[i][4];
      r.parent = r.has_parent ? via[i][3:0] : '0;
      r.last = (i == n - 1);
      pending_reports.push_back(r);
    end
  endfunction

  // Offer one item and hold it until accepted; valid stays high for the caller
  task automatic offer_item(input logic cmd, input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] b, input logic known,
                            input logic [15:0] mask);
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.first_node  <= a;
    in_ch.second_node <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (cmd == CMD_ADD) begin
      link_rows[a][b] = 1'b1;
      link_rows[b][a] = 1'b1;
    end else begin
      searches_sent++;
      forecast_reports(a, known, mask);
    end
  endtask

  // Drain, let a trailing edge update finish, then write the node count
  task automatic settle_and_write_count(input logic [CNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.num_nodes <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid   <= 1'b0;
    node_count_reg = value;
  endtask

  // Result check against the oldest queued report
  always @(posedge clk) begin : result_check
    node_report_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result for node %0d with none expected", out_ch.node_index));
      end else begin
        want = pending_reports.pop_front();
        results_checked++;
        if (out_ch.node_index !== want.node)
          report_mismatch($sformatf("node_index got %0d want %0d", out_ch.node_index, want.node));
        if (out_ch.reached !== want.reached)
          report_mismatch($sformatf("node %0d reached got %0d want %0d", want.node,
                                    out_ch.reached, want.reached));
        if (out_ch.hop_distance !== want.hops)
          report_mismatch($sformatf("node %0d hop_distance got %0d want %0d", want.node,
                                    out_ch.hop_distance, want.hops));
        if (out_ch.has_parent !== want.has_parent)
          report_mismatch($sformatf("node %0d has_parent got %0d want %0d", want.node,
                                    out_ch.has_parent, want.has_parent));
        if (out_ch.parent_node !== want.parent)
          report_mismatch($sformatf("node %0d parent_node got %0d want %0d", want.node,
                                    out_ch.parent_node, want.parent));
        if (out_ch.last_result !== want.last)
          report_mismatch($sformatf("node %0d last_result got %0d want %0d", want.node,
                                    out_ch.last_result, want.last));
        if (want.reached && int'(want.hops) > deepest_hop) deepest_hop = int'(want.hops);
      end
    end
  end

  // Result sink: random stall bursts, one long hold-off on request
  initial begin : result_sink
    int held;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results && !hold_finished) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_finished = 1'b1;
      end else if (!calm && !sink_steady && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    script_row_t script [SCRIPT_LEN];
    script_row_t row;
    logic [NODE_W-1:0] perm [16];
    logic [NODE_W-1:0] a, b, t;
    logic [CNT_W-1:0] setting;
    logic quiet_source;
    int j;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_ADD;
    in_ch.first_node  <= '0;
    in_ch.second_node <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.num_nodes  <= '0;
    for (int i = 0; i < 16; i++) link_rows[i] = '0;
    node_count_reg = NUM_NODES_RST;

    script = '{
      // empty graph: only the source is reached
      '{ROW_ITEM,  CMD_RUN, 4'd0,  4'd0,  1'b1, 16'h0001, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd15, 4'd15, 1'b1, 16'h8000, 5'd0},
      // small graph with a tie on node 2, a self loop and a split component
      '{ROW_ITEM,  CMD_ADD, 4'd0,  4'd1,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_ADD, 4'd1,  4'd2,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_ADD, 4'd2,  4'd15, 1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_ADD, 4'd15, 4'd15, 1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_ADD, 4'd0,  4'd4,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_ADD, 4'd4,  4'd2,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_ADD, 4'd5,  4'd6,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd0,  4'd0,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd15, 4'd0,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd7,  4'd10, 1'b1, 16'h0080, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd5,  4'd0,  1'b0, 16'h0000, 5'd0},
      // three nodes in use: the edge to node 15 is not followed
      '{ROW_COUNT, CMD_ADD, 4'd0,  4'd0,  1'b0, 16'h0000, 5'd3},
      '{ROW_ITEM,  CMD_RUN, 4'd0,  4'd0,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd3,  4'd0,  1'b1, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd15, 4'd0,  1'b1, 16'h0000, 5'd0},
      // single node, then a zero count that acts as one
      '{ROW_COUNT, CMD_ADD, 4'd0,  4'd0,  1'b0, 16'h0000, 5'd1},
      '{ROW_ITEM,  CMD_RUN, 4'd0,  4'd0,  1'b1, 16'h0001, 5'd0},
      '{ROW_COUNT, CMD_ADD, 4'd0,  4'd0,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd0,  4'd0,  1'b1, 16'h0001, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd1,  4'd0,  1'b1, 16'h0000, 5'd0},
      // count above the node range is clamped
      '{ROW_COUNT, CMD_ADD, 4'd0,  4'd0,  1'b0, 16'h0000, 5'd31},
      '{ROW_ITEM,  CMD_RUN, 4'd2,  4'd0,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_ADD, 4'd3,  4'd3,  1'b0, 16'h0000, 5'd0},
      '{ROW_ITEM,  CMD_RUN, 4'd3,  4'd9,  1'b1, 16'h0008, 5'd0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, back to back
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      row = script[i];
      if (row.kind == ROW_COUNT) settle_and_write_count(row.count);
      else offer_item(row.cmd, row.first, row.second, row.known, row.mask);
    end

    // Random Hamiltonian path order for the first phase
    for (int i = 0; i < 16; i++) perm[i] = 4'(i);
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end

    // Random phases: each with its own node count and idling mix
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0 || phase == PHASES - 1) setting = 5'd16;
      else if (phase == 1) setting = 5'd2;
      else if ($urandom_range(0, 7) == 0) setting = 5'($urandom_range(0, 31));
      else setting = 5'($urandom_range(1, 16));
      settle_and_write_count(setting);
      calm = (phase == PHASES - 1);
      sink_steady = (phase % 3 == 1);
      quiet_source = calm || (phase % 3 == 2);
      if (phase == 3) hold_results = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (!quiet_source && $urandom_range(0, 3) == 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        if (phase == 0 && k < 15) begin
          // lay the whole path first, searches follow
          offer_item(CMD_ADD, perm[k], perm[k + 1], 1'b0, 16'h0000);
        end else if ($urandom_range(0, 6) == 0) begin
          a = 4'($urandom_range(0, 15));
          b = ($urandom_range(0, 9) == 0) ? a : 4'($urandom_range(0, 15));
          offer_item(CMD_ADD, a, b, 1'b0, 16'h0000);
        end else begin
          a = (phase == 0) ? perm[$urandom_range(0, 1)] : 4'($urandom_range(0, 15));
          offer_item(CMD_RUN, a, 4'($urandom_range(0, 15)), 1'b0, 16'h0000);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

    $display("tb: %0d items sent, %0d searches, %0d node reports checked, %0d mismatches",
             items_sent, searches_sent, results_checked, mismatch_count);
    $display("tb: deepest hop distance seen %0d, long result hold-off %0s",
             deepest_hop, hold_finished ? "done" : "not reached");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
